// ===== rtl/hltfp_pkg.sv =====
package hltfp_pkg;

  // Frame delimiters
  localparam logic [7:0] HDR_FIRST  = 8'hA5;
  localparam logic [7:0] HDR_SECOND = 8'h5A;
  localparam logic [7:0] TAIL_BYTE  = 8'hEE;

  // Register reset and sizes
  localparam logic [15:0] TIMEOUT_RESET   = 16'd500;
  localparam int          MAX_PAYLOAD_DEF = 64;
  localparam int          LEN_W           = 7;
  localparam int          IDX_W           = 6;
  localparam int          GAP_W           = 16;
  localparam logic [15:0] GAP_MAX         = 16'hFFFF;

  // Deframer phase
  typedef enum logic [1:0] {
    PH_HDR1,
    PH_HDR2,
    PH_LEN,
    PH_BODY
  } parse_phase_t;

  // Emission sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_LOAD,
    ST_EMPTY
  } ctrl_state_t;

endpackage

// ===== rtl/hltfp_ram.sv =====
module hltfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/header_length_tail_frame_parser_top.sv =====
// Channel  Direction  Handshake            Word
// in       input      in_valid / in_ready  opcode, byte_value
// out      output     out_valid/out_ready  payload_byte, byte_index, payload_len,
//                                          is_last, has_payload
// cfg      input      cfg_valid/cfg_ready  cfg_data (timeout_ticks)
//
// A byte or tick word is taken while the sequencer is idle; the next word may follow at
// once unless a good tail starts emission. N payload words then leave, each with a store
// read, then an output register load; the input is held off until the last one is loaded.
// An empty frame gives a single word with has_payload low. out_ready low stalls the walk.
// rst is synchronous; the payload store is not cleared, only control state.
module header_length_tail_frame_parser_top #(
  parameter int MAX_PAYLOAD = hltfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        opcode,
  input  logic [7:0]                  byte_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  payload_byte,
  output logic [hltfp_pkg::IDX_W-1:0] byte_index,
  output logic [hltfp_pkg::LEN_W-1:0] payload_len,
  output logic                        is_last,
  output logic                        has_payload,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [15:0]                 cfg_data
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  hltfp_pkg::parse_phase_t phase, phase_next;
  hltfp_pkg::ctrl_state_t  state, state_next;

  logic [hltfp_pkg::LEN_W-1:0] byte_count, byte_count_next;
  logic [hltfp_pkg::LEN_W-1:0] expected_len, expected_len_next;
  logic [hltfp_pkg::GAP_W-1:0] gap_ticks, gap_ticks_next, gap_inc;
  logic [15:0]                 timeout_ticks;
  logic [hltfp_pkg::LEN_W-1:0] emit_idx, emit_idx_next;

  logic       in_fire;
  logic       mem_we, mem_re;
  logic [7:0] mem_rdata;
  logic       frame_good;
  logic       out_free;
  logic       load_byte, load_empty;
  logic       emit_last;

  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign emit_last = (emit_idx + 1'b1) == expected_len;
  assign gap_inc   = (gap_ticks == hltfp_pkg::GAP_MAX) ? gap_ticks : gap_ticks + 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= hltfp_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  // Deframer: next phase, counters and store write
  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    expected_len_next = expected_len;
    gap_ticks_next    = gap_ticks;
    mem_we            = 1'b0;
    frame_good        = 1'b0;
    if (in_fire) begin
      if (opcode) begin
        gap_ticks_next = gap_inc;
        if (gap_inc > timeout_ticks) begin
          phase_next      = hltfp_pkg::PH_HDR1;
          byte_count_next = '0;
        end
      end else begin
        gap_ticks_next = '0;
        unique case (phase)
          hltfp_pkg::PH_HDR1: begin
            if (byte_value == hltfp_pkg::HDR_FIRST) begin
              phase_next = hltfp_pkg::PH_HDR2;
            end
            byte_count_next = '0;
          end
          hltfp_pkg::PH_HDR2: begin
            phase_next = (byte_value == hltfp_pkg::HDR_SECOND) ?
                         hltfp_pkg::PH_LEN : hltfp_pkg::PH_HDR1;
          end
          hltfp_pkg::PH_LEN: begin
            if (byte_value > 8'(MAX_PAYLOAD)) begin
              phase_next = hltfp_pkg::PH_HDR1;
            end else begin
              expected_len_next = byte_value[hltfp_pkg::LEN_W-1:0];
              byte_count_next   = '0;
              phase_next        = hltfp_pkg::PH_BODY;
            end
          end
          hltfp_pkg::PH_BODY: begin
            if (byte_count < expected_len) begin
              mem_we          = 1'b1;
              byte_count_next = byte_count + 1'b1;
            end else begin
              frame_good      = (byte_value == hltfp_pkg::TAIL_BYTE);
              phase_next      = hltfp_pkg::PH_HDR1;
              byte_count_next = '0;
            end
          end
          default: phase_next = hltfp_pkg::PH_HDR1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= hltfp_pkg::PH_HDR1;
      byte_count   <= '0;
      expected_len <= '0;
      gap_ticks    <= '0;
    end else begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      expected_len <= expected_len_next;
      gap_ticks    <= gap_ticks_next;
    end
  end

  // Payload store
  hltfp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (byte_count[AW-1:0]),
    .wdata (byte_value),
    .re    (mem_re),
    .raddr (emit_idx[AW-1:0]),
    .rdata (mem_rdata)
  );

  // Emission sequencer: next state
  always_comb begin
    state_next    = state;
    emit_idx_next = emit_idx;
    unique case (state)
      hltfp_pkg::ST_IDLE: begin
        if (frame_good) begin
          emit_idx_next = '0;
          state_next    = (expected_len == '0) ? hltfp_pkg::ST_EMPTY : hltfp_pkg::ST_RD;
        end
      end
      hltfp_pkg::ST_RD: state_next = hltfp_pkg::ST_LOAD;
      hltfp_pkg::ST_LOAD: begin
        if (out_free) begin
          emit_idx_next = emit_idx + 1'b1;
          state_next    = emit_last ? hltfp_pkg::ST_IDLE : hltfp_pkg::ST_RD;
        end
      end
      hltfp_pkg::ST_EMPTY: begin
        if (out_free) begin
          state_next = hltfp_pkg::ST_IDLE;
        end
      end
      default: state_next = hltfp_pkg::ST_IDLE;
    endcase
  end

  // Emission sequencer: outputs
  always_comb begin
    in_ready   = 1'b0;
    mem_re     = 1'b0;
    load_byte  = 1'b0;
    load_empty = 1'b0;
    unique case (state)
      hltfp_pkg::ST_IDLE:  in_ready   = 1'b1;
      hltfp_pkg::ST_RD:    mem_re     = 1'b1;
      hltfp_pkg::ST_LOAD:  load_byte  = out_free;
      hltfp_pkg::ST_EMPTY: load_empty = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hltfp_pkg::ST_IDLE;
      emit_idx <= '0;
    end else begin
      state    <= state_next;
      emit_idx <= emit_idx_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_byte || load_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte) begin
      payload_byte <= mem_rdata;
      byte_index   <= hltfp_pkg::IDX_W'(emit_idx);
      payload_len  <= expected_len;
      is_last      <= emit_last;
      has_payload  <= 1'b1;
    end else if (load_empty) begin
      payload_byte <= '0;
      byte_index   <= '0;
      payload_len  <= '0;
      is_last      <= 1'b1;
      has_payload  <= 1'b0;
    end
  end

  // Checks
  a_no_write_while_walking: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == hltfp_pkg::ST_IDLE)
    else $error("payload store written during emission");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == hltfp_pkg::PH_BODY |-> byte_count <= expected_len)
    else $error("byte count ran past frame length");

  a_load_after_read: assert property (@(posedge clk) disable iff (rst)
    $rose(state == hltfp_pkg::ST_LOAD) |-> $past(state) == hltfp_pkg::ST_RD)
    else $error("output load without a store read");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_payload |-> is_last && payload_len == '0)
    else $error("empty result not marked last");

endmodule
